/* hdl/mrrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrrc_pkg
// shared constants, beat and result types and the byte-wide crc-16 update
// ----------------------------------------------------------------------------
package mrrc_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 4;
	localparam int CRC_W  = 16;
	localparam int WORD_W = 16;
	localparam int RAW_W  = 32;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	// byte positions within the reply frame
	localparam logic [IDX_W-1:0] FRAME_LEN = 4'd11;
	localparam logic [IDX_W-1:0] CRC_SPAN  = 4'd9;
	localparam logic [IDX_W-1:0] IDX_FIRST = 4'd0;
	localparam logic [IDX_W-1:0] IDX_VH0   = 4'd3;
	localparam logic [IDX_W-1:0] IDX_VH1   = 4'd4;
	localparam logic [IDX_W-1:0] IDX_VL0   = 4'd5;
	localparam logic [IDX_W-1:0] IDX_VL1   = 4'd6;
	localparam logic [IDX_W-1:0] IDX_DW0   = 4'd7;
	localparam logic [IDX_W-1:0] IDX_DW1   = 4'd8;
	localparam logic [IDX_W-1:0] IDX_CRCLO = 4'd9;
	localparam logic [IDX_W-1:0] IDX_CRCHI = 4'd10;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              frame_start;
	} beat_t;

	typedef struct packed {
		logic [RAW_W-1:0]  raw_value;
		logic [WORD_W-1:0] decimal_places;
		logic              crc_ok;
	} result_t;

	// one byte through crc-16/modbus, eight reflected shifts
	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hdl/mrrc_in_reg.sv */
// ----------------------------------------------------------------------------
// mrrc_in_reg
// input register: holds one received beat until the frame logic takes it
// ----------------------------------------------------------------------------
module mrrc_in_reg
	import mrrc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  beat_t beat_in,
	input  logic  take,
	output logic  valid_s1,
	output beat_t beat_s1
);

	// refill in the same cycle the held beat is taken
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= beat_in;
		end
	end

endmodule

/* hdl/mrrc_frame.sv */
// ----------------------------------------------------------------------------
// mrrc_frame
// frame tracking, crc accumulation, word capture and crc check
// ----------------------------------------------------------------------------
module mrrc_frame
	import mrrc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  beat_t   beat_s1,
	output logic    res_push,
	output result_t res
);

	logic [IDX_W-1:0]  byte_index_q;
	logic [CRC_W-1:0]  crc_accum_q;
	logic [WORD_W-1:0] value_high_q;
	logic [WORD_W-1:0] value_low_q;
	logic [WORD_W-1:0] decimal_word_q;
	logic [BYTE_W-1:0] crc_low_byte_q;

	logic              restart;
	logic [IDX_W-1:0]  idx;
	logic [CRC_W-1:0]  crc_base;
	logic [CRC_W-1:0]  crc_next;
	logic [CRC_W-1:0]  rx_crc;
	logic              ok;

	// start flag or a stray index opens a new frame
	assign restart  = beat_s1.frame_start || (byte_index_q >= FRAME_LEN);
	assign idx      = restart ? IDX_FIRST : byte_index_q;
	assign crc_base = restart ? CRC_INIT : crc_accum_q;
	assign crc_next = crc16_byte(crc_base, beat_s1.rx_byte);

	assign rx_crc   = {beat_s1.rx_byte, crc_low_byte_q};
	assign ok       = (rx_crc == crc_base);
	assign res_push = step && (idx == IDX_CRCHI);

	always_comb begin
		res.crc_ok         = ok;
		res.raw_value      = ok ? {value_high_q, value_low_q} : '0;
		res.decimal_places = ok ? decimal_word_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= IDX_FIRST;
			crc_accum_q  <= CRC_INIT;
		end else if (step) begin
			if (idx < CRC_SPAN) begin
				crc_accum_q  <= crc_next;
				byte_index_q <= idx + 1'b1;
			end else if (idx == IDX_CRCLO) begin
				crc_accum_q  <= crc_base;
				byte_index_q <= idx + 1'b1;
			end else begin
				crc_accum_q  <= CRC_INIT;
				byte_index_q <= IDX_FIRST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_high_q   <= '0;
			value_low_q    <= '0;
			decimal_word_q <= '0;
			crc_low_byte_q <= '0;
		end else if (step) begin
			unique case (idx) inside
				IDX_VH0, IDX_VH1: value_high_q   <= {value_high_q[BYTE_W-1:0], beat_s1.rx_byte};
				IDX_VL0, IDX_VL1: value_low_q    <= {value_low_q[BYTE_W-1:0], beat_s1.rx_byte};
				IDX_DW0, IDX_DW1: decimal_word_q <= {decimal_word_q[BYTE_W-1:0], beat_s1.rx_byte};
				IDX_CRCLO:        crc_low_byte_q <= beat_s1.rx_byte;
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= IDX_CRCHI)
		else $error("byte index beyond frame end");

	a_end_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (byte_index_q == IDX_FIRST) && (crc_accum_q == CRC_INIT))
		else $error("frame state not rearmed after check");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !res.crc_ok |-> (res.raw_value == '0) && (res.decimal_places == '0))
		else $error("failed frame carries data");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		step && !beat_s1.frame_start && (byte_index_q < IDX_CRCHI)
		|=> byte_index_q == $past(byte_index_q) + 1'b1)
		else $error("byte index did not advance");
`endif

endmodule

/* hdl/mrrc_out_buf.sv */
// ----------------------------------------------------------------------------
// mrrc_out_buf
// result register with skid entry; the frame side waits only while that entry is full
// ----------------------------------------------------------------------------
module mrrc_out_buf
	import mrrc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    buf_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;
	logic    load_main;
	logic    load_skid;

	assign buf_ready = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = main_q;
	assign pop       = out_valid_q && out_ready;
	assign load_main = push && !skid_valid_q && (!out_valid_q || pop);
	assign load_skid = push && !skid_valid_q && out_valid_q && !pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (load_main) begin
			out_valid_q <= 1'b1;
		end else if (load_skid) begin
			skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && pop) begin
			main_q <= skid_q;
		end else if (load_main) begin
			main_q <= push_data;
		end
		if (load_skid) begin
			skid_q <= push_data;
		end
	end

`ifndef SYNTH
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty result register");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed into full buffer");

	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_valid_q && !out_ready |=> skid_valid_q)
		else $error("stalled result not parked in skid entry");
`endif

endmodule

/* hdl/modbus_read_response_checker.sv */
// ----------------------------------------------------------------------------
// modbus_read_response_checker
// crc-16/modbus check of an 11-byte read reply and extraction of its words
// ----------------------------------------------------------------------------
//
// channel  direction  handshake             payload
// -------  ---------  --------------------  -----------------------------------
// in       to block   in_valid / in_ready   rx_byte[7:0], frame_start
// out      from block out_valid / out_ready raw_value[31:0] signed,
//                                           decimal_places[15:0], crc_ok
//
// one input beat per cycle sustained while the skid entry is empty; the beat
// carrying byte 10 passes the input register, then its result is loaded into
// the result register (or into the skid entry while out stalls)
// the byte-wide crc update (eight unrolled shift steps) sits between the
// input register and the frame state
// reset (arst_n low) clears the frame position to byte 0 and the crc to 0xffff
// an out stall parks one result in a skid entry; while that entry is full no
// beat leaves the input register, so in_ready drops as soon as that register
// holds a beat, whatever byte it carries
//
// bytes 0 to 8 feed the crc; bytes 3-4, 5-6 and 7-8 are captured big-endian
// byte 9 is the received crc low byte; byte 10 the high byte, which triggers
// the compare and the single result beat of the frame
// frame_start forces the beat to byte 0 and restarts the crc from 0xffff
// after byte 10 the next byte begins a new frame even without frame_start
// on a crc mismatch raw_value and decimal_places are zero and crc_ok is low
// ----------------------------------------------------------------------------
module modbus_read_response_checker
	import mrrc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [BYTE_W-1:0]        rx_byte,
	input  logic                     frame_start,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [RAW_W-1:0]  raw_value,
	output logic [WORD_W-1:0]        decimal_places,
	output logic                     crc_ok
);

	beat_t   beat_in;
	beat_t   beat_s1;
	logic    valid_s1;
	logic    buf_ready;
	logic    step;
	logic    res_push;
	result_t res;
	result_t out_data;

	assign beat_in.rx_byte     = rx_byte;
	assign beat_in.frame_start = frame_start;

	// a held beat moves on whenever the result buffer has room
	assign step = valid_s1 && buf_ready;

	mrrc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.beat_in  (beat_in),
		.take     (step),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	// frame position, crc and captured words
	mrrc_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.beat_s1  (beat_s1),
		.res_push (res_push),
		.res      (res)
	);

	// result register plus skid entry
	mrrc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.buf_ready (buf_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign raw_value      = signed'(out_data.raw_value);
	assign decimal_places = out_data.decimal_places;
	assign crc_ok         = out_data.crc_ok;

endmodule

/* dv/modbus_reply_scoreboard.sv */
// ----------------------------------------------------------------------------
// modbus_reply_scoreboard
// watches both channels, predicts each reply verdict and compares it
// ----------------------------------------------------------------------------
module modbus_reply_scoreboard
	import mrrc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [BYTE_W-1:0]       rx_byte,
	input  logic                    frame_start,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [RAW_W-1:0] raw_value,
	input  logic [WORD_W-1:0]       decimal_places,
	input  logic                    crc_ok,
	output int                      fail_count,
	output int                      pending,
	output int                      good_replies,
	output int                      bad_replies
);

	// predicted reply state
	logic [IDX_W-1:0]  next_pos;
	logic [CRC_W-1:0]  crc_run;
	logic [WORD_W-1:0] word_hi;
	logic [WORD_W-1:0] word_lo;
	logic [WORD_W-1:0] dp_word;
	logic [BYTE_W-1:0] crc_lo;

	result_t replies_due[$];

	function automatic logic [CRC_W-1:0] crc_mix(input logic [CRC_W-1:0] acc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = acc ^ {8'h00, b};
		repeat (8) c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
		return c;
	endfunction

	task automatic flag(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// one accepted byte through the predicted frame state
	task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic s);
		logic [IDX_W-1:0] pos;
		logic             match;
		result_t          verdict;
		pos = next_pos;
		if (s || pos >= FRAME_LEN) begin
			pos = IDX_FIRST;
			crc_run = CRC_INIT;
		end
		if (pos < CRC_SPAN) begin
			crc_run = crc_mix(crc_run, b);
			case (pos)
				IDX_VH0, IDX_VH1: word_hi = {word_hi[7:0], b};
				IDX_VL0, IDX_VL1: word_lo = {word_lo[7:0], b};
				IDX_DW0, IDX_DW1: dp_word = {dp_word[7:0], b};
				default: ;
			endcase
			next_pos = pos + 1'b1;
		end else if (pos == IDX_CRCLO) begin
			crc_lo = b;
			next_pos = pos + 1'b1;
		end else begin
			match = ({b, crc_lo} == crc_run);
			verdict.crc_ok = match;
			verdict.raw_value = match ? {word_hi, word_lo} : '0;
			verdict.decimal_places = match ? dp_word : '0;
			replies_due.push_back(verdict);
			pending++;
			next_pos = IDX_FIRST;
			crc_run = CRC_INIT;
		end
	endtask

	task automatic compare_reply();
		result_t want;
		if (replies_due.size() == 0) begin
			flag($sformatf("result with nothing pending raw=%h dp=%h ok=%b",
				raw_value, decimal_places, crc_ok));
		end else begin
			want = replies_due.pop_front();
			pending--;
			if (want.crc_ok) good_replies++;
			else bad_replies++;
			if (raw_value !== want.raw_value)
				flag($sformatf("raw_value %h, want %h", raw_value, want.raw_value));
			if (decimal_places !== want.decimal_places)
				flag($sformatf("decimal_places %h, want %h", decimal_places,
					want.decimal_places));
			if (crc_ok !== want.crc_ok)
				flag($sformatf("crc_ok %b, want %b", crc_ok, want.crc_ok));
		end
	endtask

	initial begin
		fail_count = 0;
		good_replies = 0;
		bad_replies = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_pos = IDX_FIRST;
			crc_run = CRC_INIT;
			word_hi = '0;
			word_lo = '0;
			dp_word = '0;
			crc_lo = '0;
			replies_due.delete();
			pending = 0;
		end else begin
			if (in_valid && in_ready) absorb_byte(rx_byte, frame_start);
			if (out_valid && out_ready) compare_reply();
		end
	end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// reply-level stimulus for the modbus read-reply checker, with a scoreboard
// that predicts every crc verdict and extracted word from the byte stream
// ----------------------------------------------------------------------------
module testbench;
	import mrrc_pkg::*;

	localparam int RANDOM_BEATS   = 550;
	localparam int CALM_FROM      = 470;  // no idling on either side past this
	localparam int WATCHDOG_LIMIT = 2000; // cycles with no beat on either channel
	localparam int DRAIN_CYCLES   = 10;   // extra cycles waited for stray results after the last predicted one

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [BYTE_W-1:0]       rx_byte = '0;
	logic                    frame_start = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [RAW_W-1:0] raw_value;
	logic [WORD_W-1:0]       decimal_places;
	logic                    crc_ok;

	int fail_count;
	int pending;
	int good_replies;
	int bad_replies;

	int beats_sent = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int in_gap_odds = 6;  // 0 means no input gaps for the current reply
	bit calm = 1'b0;

	always #4 clk = ~clk;

	modbus_read_response_checker uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.frame_start    (frame_start),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.raw_value      (raw_value),
		.decimal_places (decimal_places),
		.crc_ok         (crc_ok)
	);

	modbus_reply_scoreboard scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.frame_start    (frame_start),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.raw_value      (raw_value),
		.decimal_places (decimal_places),
		.crc_ok         (crc_ok),
		.fail_count     (fail_count),
		.pending        (pending),
		.good_replies   (good_replies),
		.bad_replies    (bad_replies)
	);

	// result side back-pressure: random bursts of stalled cycles, none once calm
	// a stall burst lasting past the skid entry is what makes in_ready drop
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog: only quiet stretches count, so long runs never trip it
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat on either channel for %0d cycles", idle_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// crc-16/modbus over the nine body bytes, used to build the crc of every frame
	function automatic logic [15:0] body_crc16(input logic [71:0] body);
		logic [15:0] acc;
		acc = 16'hFFFF;
		for (int i = 0; i < 9; i++) begin
			acc ^= {8'h00, body[71-8*i -: 8]};
			for (int k = 0; k < 8; k++)
				acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
		end
		return acc;
	endfunction

	// bytes lean towards the corner values so sign and carry edges come up often
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// body of a reply: address, function, count, value (4 bytes), decimals (2)
	function automatic logic [71:0] pick_body();
		logic [71:0] body;
		for (int i = 0; i < 9; i++)
			body[71-8*i -: 8] = pick_byte();
		case ($urandom_range(0, 19))
			0: body = '0;
			1: body = '1;
			2: body[47:16] = 32'h8000_0000;  // most negative raw value
			3: body[47:16] = 32'h7FFF_FFFF;  // most positive raw value
			default: ;
		endcase
		return body;
	endfunction

	// one byte beat; valid and payload hold until the handshake, then an
	// optional gap with valid low
	task automatic push_beat(input logic [7:0] b, input logic s);
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= s;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		if (!calm && in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// a reply frame: body, crc low, crc high; spoil flips one bit anywhere in
	// the frame, cut sends only the leading bytes (a broken-off reply)
	task automatic ship_frame(input logic [71:0] body, input bit with_start,
		input bit spoil, input int cut);
		logic [15:0] crc;
		logic [87:0] frame;
		crc = body_crc16(body);
		frame = {body, crc[7:0], crc[15:8]};
		if (spoil) frame[$urandom_range(0, 87)] ^= 1'b1;
		for (int i = 0; i < cut; i++)
			push_beat(frame[87-8*i -: 8], with_start && i == 0);
	endtask

	initial begin
		int pick;
		int target;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a reply broken off after three bytes and restarted by the
		// start flag, a good all-ones reply (raw value -1, decimals 0xffff), then
		// an all-zero reply with a corrupted bit that follows without a start
		// flag, relying on the frame end returning to byte 0
		push_beat(8'h00, 1'b1);
		push_beat(8'h7F, 1'b0);
		push_beat(8'h80, 1'b0);
		ship_frame({9{8'hFF}}, 1'b1, 1'b0, 11);
		ship_frame(72'h0, 1'b0, 1'b1, 11);

		// random: mostly well-formed replies with random content, the rest
		// corrupted, cut short or plain noise with random start flags
		target = beats_sent + RANDOM_BEATS;
		while (beats_sent < target) begin
			if (beats_sent >= target - (RANDOM_BEATS - CALM_FROM)) calm = 1'b1;
			case ($urandom_range(0, 3))
				0: in_gap_odds = 0;
				1: in_gap_odds = 3;
				default: in_gap_odds = 8;
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 65)
				ship_frame(pick_body(), $urandom_range(0, 4) != 0, 1'b0, 11);
			else if (pick < 80)
				ship_frame(pick_body(), $urandom_range(0, 3) != 0, 1'b1, 11);
			else if (pick < 90)
				ship_frame(pick_body(), 1'b1, 1'b0, $urandom_range(1, 10));
			else
				repeat ($urandom_range(1, 6))
					push_beat(pick_byte(), $urandom_range(0, 3) == 0);
		end
		in_valid <= 1'b0;

		// let every predicted reply come out, then DRAIN_CYCLES more for strays
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d byte beats with restarts, cut-off replies and stalls",
			beats_sent);
		$display("replies checked: %0d with matching crc, %0d rejected",
			good_replies, bad_replies);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
